// ----- design/rpn_pkg.sv -----
package rpn_pkg;

    localparam int WORD_W = 32;
    localparam int ITER_W = 5;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(WORD_W - 1);

    // Token kinds. The spare code is ignored by the sequencer.
    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5,
        OP_EQ   = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_FULL  = 2'd2,
        ST_DIVZ  = 2'd3
    } status_t;

    // What the token does to the stack once its result is committed.
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP,
        ACT_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NEGB,
        S_MUL,
        S_DIV,
        S_FIX,
        S_DONE
    } state_t;

    // Control of the shared adder.
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic              sub;
    } alu_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum;
        logic              carry;
    } alu_rsp_t;

endpackage

// ----- design/rpn_token_if.sv -----
interface rpn_token_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  op;
    logic signed [31:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink (input valid, input op, input operand, output ready);
endinterface

// ----- design/rpn_result_if.sv -----
interface rpn_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic        [1:0]  status;
    logic               finished;
    logic        [4:0]  depth;

    modport source (output valid, output top_value, output status, output finished,
                    output depth, input ready);
    modport sink (input valid, input top_value, input status, input finished,
                  input depth, output ready);
endinterface

// ----- design/rpn_alu.sv -----
module rpn_alu
    import rpn_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [WORD_W:0] total;

    // Subtraction is an add of the inverted operand with a carry in; the carry out
    // is set when x is not below y.
    assign total = {1'b0, req.x} + {1'b0, (req.sub ? ~req.y : req.y)}
                 + (WORD_W+1)'(req.sub);
    assign rsp.sum   = total[WORD_W-1:0];
    assign rsp.carry = total[WORD_W];

endmodule

// ----- design/rpn_integer_stack_evaluator_core.sv -----
// Reverse Polish integer evaluator with a bounded stack of signed 32-bit entries.
// Tokens come in on the token channel (op and operand) and every token gives
// exactly one transfer on the result channel: the top of the stack, a status
// code, a finished flag for a completed equals, and the stack depth.
// A token is taken only while the sequencer is idle; it then runs through one
// shared 32-bit adder. Push, equals, add, subtract, the spare code and any error
// go from the execute step straight to the done step; multiply runs 32 shift-add
// steps and divide or modulus two sign steps, 32 restoring steps and one sign
// fix before the done step. A new token is not taken until the current one has
// committed its result and the sequencer is idle again.
// The result sits in an output register, so the next token is accepted while
// the previous result still waits; if the receiver stalls, a finished token
// holds in its last step until the output register is free, and the stack is
// only updated at that moment. Reset empties the stack and drops any pending
// result; the entry store itself is not cleared, as only written entries are
// ever read.
module rpn_integer_stack_evaluator_core
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    rpn_token_if.sink    token,
    rpn_result_if.source result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Stack entries. The topmost entry is also mirrored in top_reg so that a
    // binary operator needs a single read of the memory.
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] top_reg, top_next;
    op_t               op_reg, op_next;
    logic [WORD_W-1:0] operand_reg, operand_next;
    status_t           status_reg, status_next;
    act_t              act_reg, act_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic [WORD_W-1:0] z_reg, z_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic              a_neg_reg, a_neg_next;
    logic              b_neg_reg, b_neg_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_top_reg, out_top_next;
    status_t           out_status_reg, out_status_next;
    logic              out_finished_reg, out_finished_next;
    logic [4:0]        out_depth_reg, out_depth_next;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic              few_entries;
    logic              is_full;
    logic              b_zero;
    logic              commit;
    logic [WORD_W-1:0] fix_val;
    logic              fix_neg;
    logic [WORD_W-1:0] div_shift;

    rpn_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign few_entries = count_reg < CW'(2);
    assign is_full     = count_reg == CW'(STACK_DEPTH);
    assign b_zero      = top_reg == '0;
    assign commit      = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign rd_addr     = AW'(count_reg - CW'(2));
    assign fix_val     = (op_reg == OP_DIV) ? z_reg : x_reg;
    assign fix_neg     = (op_reg == OP_DIV) ? (a_neg_reg ^ b_neg_reg) : a_neg_reg;
    assign div_shift   = {x_reg[WORD_W-2:0], z_reg[WORD_W-1]};

    assign token.ready      = state_reg == S_IDLE;
    assign result.valid     = out_valid_reg;
    assign result.top_value = out_top_reg;
    assign result.status    = out_status_reg;
    assign result.finished  = out_finished_reg;
    assign result.depth     = out_depth_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (token.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                if (!few_entries && op_reg == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                if (!few_entries && !b_zero && (op_reg == OP_DIV || op_reg == OP_MOD))
                begin
                    state_next = S_NEGB;
                end
            end
            S_NEGB:
            begin
                state_next = S_DIV;
            end
            S_MUL:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Operand selection for the shared adder in each step.
    always_comb
    begin
        alu_req.x   = '0;
        alu_req.y   = top_reg;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        alu_req.x = rd_data_reg;
                    end
                    OP_SUB:
                    begin
                        alu_req.x   = rd_data_reg;
                        alu_req.sub = 1'b1;
                    end
                    default:
                    begin
                        // Negation of the lower operand, for the divider.
                        alu_req.y   = rd_data_reg;
                        alu_req.sub = 1'b1;
                    end
                endcase
            end
            S_NEGB:
            begin
                alu_req.sub = 1'b1;
            end
            S_MUL:
            begin
                alu_req.x = x_reg;
                alu_req.y = z_reg[0] ? y_reg : '0;
            end
            S_DIV:
            begin
                alu_req.x   = div_shift;
                alu_req.y   = y_reg;
                alu_req.sub = 1'b1;
            end
            S_FIX:
            begin
                alu_req.y   = fix_val;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    // Datapath and stack update.
    always_comb
    begin
        op_next           = op_reg;
        operand_next      = operand_reg;
        status_next       = status_reg;
        act_next          = act_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        iter_next         = iter_reg;
        res_next          = res_reg;
        a_neg_next        = a_neg_reg;
        b_neg_next        = b_neg_reg;
        count_next        = count_reg;
        top_next          = top_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_top_next      = out_top_reg;
        out_status_next   = out_status_reg;
        out_finished_next = out_finished_reg;
        out_depth_next    = out_depth_reg;
        mem_we            = 1'b0;
        mem_waddr         = rd_addr;
        mem_wdata         = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (token.valid)
                begin
                    op_next      = op_t'(token.op);
                    operand_next = token.operand;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                act_next    = ACT_NONE;
                iter_next   = '0;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            act_next = ACT_PUSH;
                        end
                    end
                    OP_ADD, OP_SUB:
                    begin
                        if (few_entries)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            act_next = ACT_POP;
                            res_next = alu_rsp.sum;
                        end
                    end
                    OP_MUL:
                    begin
                        if (few_entries)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            act_next = ACT_POP;
                        end
                        x_next = '0;
                        y_next = rd_data_reg;
                        z_next = top_reg;
                    end
                    OP_DIV, OP_MOD:
                    begin
                        if (few_entries)
                        begin
                            status_next = ST_UNDER;
                        end
                        else if (b_zero)
                        begin
                            status_next = ST_DIVZ;
                        end
                        else
                        begin
                            act_next = ACT_POP;
                        end
                        z_next     = rd_data_reg[WORD_W-1] ? alu_rsp.sum : rd_data_reg;
                        a_neg_next = rd_data_reg[WORD_W-1];
                        b_neg_next = top_reg[WORD_W-1];
                    end
                    OP_EQ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_UNDER;
                        end
                        else
                        begin
                            act_next = ACT_CLEAR;
                        end
                    end
                    default:
                    begin
                        act_next = ACT_NONE;
                    end
                endcase
            end
            S_NEGB:
            begin
                y_next    = top_reg[WORD_W-1] ? alu_rsp.sum : top_reg;
                x_next    = '0;
                iter_next = '0;
            end
            S_MUL:
            begin
                x_next    = alu_rsp.sum;
                y_next    = {y_reg[WORD_W-2:0], 1'b0};
                z_next    = {1'b0, z_reg[WORD_W-1:1]};
                iter_next = iter_reg + ITER_W'(1);
                res_next  = alu_rsp.sum;
            end
            S_DIV:
            begin
                // Restoring step: keep the difference when the divisor fits.
                x_next    = alu_rsp.carry ? alu_rsp.sum : div_shift;
                z_next    = {z_reg[WORD_W-2:0], alu_rsp.carry};
                iter_next = iter_reg + ITER_W'(1);
            end
            S_FIX:
            begin
                res_next = fix_neg ? alu_rsp.sum : fix_val;
            end
            S_DONE:
            begin
                if (commit)
                begin
                    out_valid_next    = 1'b1;
                    out_status_next   = status_reg;
                    out_finished_next = act_reg == ACT_CLEAR;
                    out_top_next      = (count_reg == '0) ? '0 : top_reg;
                    case (act_reg)
                        ACT_PUSH:
                        begin
                            count_next   = count_reg + CW'(1);
                            top_next     = operand_reg;
                            out_top_next = operand_reg;
                            mem_we       = 1'b1;
                            mem_waddr    = AW'(count_reg);
                            mem_wdata    = operand_reg;
                        end
                        ACT_POP:
                        begin
                            count_next   = count_reg - CW'(1);
                            top_next     = res_reg;
                            out_top_next = res_reg;
                            mem_we       = 1'b1;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                    out_depth_next = 5'(count_next);
                end
            end
            default:
            begin
                iter_next = iter_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg          <= top_next;
        op_reg           <= op_next;
        operand_reg      <= operand_next;
        status_reg       <= status_next;
        act_reg          <= act_next;
        x_reg            <= x_next;
        y_reg            <= y_next;
        z_reg            <= z_next;
        iter_reg         <= iter_next;
        res_reg          <= res_next;
        a_neg_reg        <= a_neg_next;
        b_neg_reg        <= b_neg_next;
        out_top_reg      <= out_top_next;
        out_status_reg   <= out_status_next;
        out_finished_reg <= out_finished_next;
        out_depth_reg    <= out_depth_next;
    end

    // Stack memory: one write port, one registered read of the entry below the top.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // A completed expression always leaves an empty stack and a clean status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.finished) |-> (result.depth == '0 && result.status == ST_OK))
        else $error("finished result with non-empty stack or error status");

    // A full-stack report only happens with the stack at its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_FULL) |-> (result.depth == 5'(STACK_DEPTH)))
        else $error("stack full reported below the limit");

    // A committed push grows the stack by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (commit && act_reg == ACT_PUSH) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not grow the stack by one");

    // The entry count never passes the stack size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond its limit");

    // The stack only changes when a result is committed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(count_reg))
        else $error("stack count changed without a committed result");

endmodule

// ----- test/rpn_integer_stack_evaluator_core_tb.sv -----
// Testbench for the reverse Polish stack evaluator.
//
// Tokens are driven on the token channel at the falling clock edge, and both
// channels are sampled at the rising edge. Each token that is accepted is run
// through a behavioural model of the stack held in this module. The model's
// outcome is queued, and the checker compares every result transfer, field by
// field, against the oldest queued outcome.
//
// The run is made of three tests. A short directed sequence comes first. It
// covers the error cases, wrap-around, the most negative value divided by
// minus one, truncating division and the spare op code. The stack is then
// filled beyond its depth after the result side is asked to hold off for a long
// stretch, so that the block backs up and stalls its input. Last come random
// expressions, mixed with runs of arbitrary tokens. Both sides pause at random
// between transfers, and the pacing changes from one expression to the next.
module rpn_integer_stack_evaluator_core_tb;
    import rpn_pkg::*;

    localparam int CLOCK_PERIOD    = 12;
    localparam int STACK_ENTRIES   = 16;
    localparam int MAX_GAP         = 18;
    localparam int HOLD_OFF_CYCLES = 160;
    // The slowest token is a divide or modulus; this drain period is waited out
    // after the last expected result, so that a stray transfer would still show.
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_TOKENS   = 650;
    localparam int WATCHDOG_CYCLES = 500000;

    // Op code 7 is not a token kind. The block must treat it as a no-op.
    localparam logic [2:0]         OP_SPARE = 3'd7;
    localparam logic signed [31:0] INT_MAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] INT_MIN  = 32'sh8000_0000;

    typedef enum int {
        PACE_NONE,
        PACE_SOME,
        PACE_HEAVY
    } pace_t;

    // One expected transfer on the result channel.
    typedef struct packed {
        logic [31:0] top_value;
        status_t     status;
        logic        finished;
        logic [4:0]  depth;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rpn_token_if  token_ch ();
    rpn_result_if result_ch ();

    rpn_integer_stack_evaluator_core #(
        .STACK_DEPTH (STACK_ENTRIES)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .token  (token_ch),
        .result (result_ch)
    );

    // Model of the evaluator's stack. Only entries below model_depth are
    // ever read, in the same way as in the block.
    logic [31:0] model_stack [STACK_ENTRIES];
    int          model_depth = 0;

    outcome_t    pending_results [$];

    pace_t       pace = PACE_NONE;
    bit          hold_request = 1'b0;

    int          failures = 0;
    int          tokens_sent = 0;
    int          results_checked = 0;
    int          finished_seen = 0;
    int          holds_done = 0;
    int          status_seen [4] = '{0, 0, 0, 0};

    always
    begin
        #(CLOCK_PERIOD / 2) clk = 1'b1;
        #(CLOCK_PERIOD / 2) clk = 1'b0;
    end

    // Applies one token to the model stack and returns the result that the
    // block must produce for it. Errors leave the stack untouched. Division
    // is worked out at 64 bits, so that the most negative value divided by
    // minus one wraps rather than overflows. Truncation toward zero and a
    // remainder that takes the dividend's sign follow from the language.
    function automatic outcome_t evaluate_token(input logic [2:0] op,
                                                input logic [31:0] operand);
        outcome_t    res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [63:0] product;
        longint      sa;
        longint      sb;

        res = '0;
        res.status = ST_OK;
        r = '0;
        case (op)
            OP_PUSH:
            begin
                if (model_depth >= STACK_ENTRIES)
                    res.status = ST_FULL;
                else
                begin
                    model_stack[model_depth] = operand;
                    model_depth++;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
            begin
                if (model_depth < 2)
                    res.status = ST_UNDER;
                else
                begin
                    a = model_stack[model_depth - 2];
                    b = model_stack[model_depth - 1];
                    sa = $signed(a);
                    sb = $signed(b);
                    if ((op == OP_DIV || op == OP_MOD) && b == '0)
                        res.status = ST_DIVZ;
                    else
                    begin
                        case (op)
                            OP_ADD: r = a + b;
                            OP_SUB: r = a - b;
                            OP_MUL:
                            begin
                                product = 64'(a) * 64'(b);
                                r = product[31:0];
                            end
                            OP_DIV: r = 32'(sa / sb);
                            default: r = 32'(sa % sb);
                        endcase
                        model_depth--;
                        model_stack[model_depth - 1] = r;
                    end
                end
            end
            OP_EQ:
            begin
                if (model_depth == 0)
                    res.status = ST_UNDER;
                else
                begin
                    res.top_value = model_stack[model_depth - 1];
                    res.finished = 1'b1;
                    model_depth = 0;
                end
            end
            default:
            begin
                // The spare code changes nothing.
            end
        endcase
        if (!res.finished)
            res.top_value = (model_depth == 0) ? '0 : model_stack[model_depth - 1];
        res.depth = 5'(model_depth);
        return res;
    endfunction

    // Number of cycles that either side waits before its next transfer.
    function automatic int draw_wait();
        case (pace)
            PACE_NONE: return 0;
            PACE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, MAX_GAP)) : 0;
            default: return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // Operands lean towards the corners: the extremes, zero, minus one and
    // small values of either sign, so that division and wrap-around get
    // plenty of interesting pairs.
    function automatic logic [31:0] draw_operand();
        case ($urandom_range(0, 9))
            0: return INT_MAX;
            1: return INT_MIN;
            2: return '0;
            3: return '1;
            4, 5, 6: return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom();
        endcase
    endfunction

    // Offers one token and waits for its transfer. Valid is only lowered
    // when a gap has been drawn, so a back-to-back token keeps valid high
    // rather than lowering and raising it at the same edge. The task is
    // entered and left just after a falling edge.
    task automatic send_token(input logic [2:0] op, input logic [31:0] operand);
        int gap;

        gap = draw_wait();
        if (gap > 0)
        begin
            token_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        token_ch.valid   <= 1'b1;
        token_ch.op      <= op;
        token_ch.operand <= operand;
        do
            @(posedge clk);
        while (token_ch.ready !== 1'b1);
        pending_results.push_back(evaluate_token(op, operand));
        tokens_sent++;
        @(negedge clk);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%08h (%0d), actual 0x%08h (%0d)",
                     $time, name, want, $signed(want), got, $signed(got));
            failures++;
        end
    endtask

    // Each result transfer is checked against the oldest outstanding
    // outcome. A transfer that arrives while nothing is outstanding is an
    // error in its own right.
    always @(posedge clk)
    begin
        outcome_t want;

        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result transfer, top_value 0x%08h status %0d",
                         $time, result_ch.top_value, result_ch.status);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("top_value", want.top_value, result_ch.top_value);
                compare_field("status", 32'(want.status), 32'(result_ch.status));
                compare_field("finished", 32'(want.finished), 32'(result_ch.finished));
                compare_field("depth", 32'(want.depth), 32'(result_ch.depth));
                results_checked++;
                status_seen[result_ch.status]++;
                if (result_ch.finished === 1'b1)
                    finished_seen++;
            end
        end
    end

    // Result side. Before each transfer it draws a pause with ready low.
    // When a hold-off has been requested it instead keeps ready low for a
    // long, fixed stretch, so that the block has to back up.
    initial
    begin
        int stall;

        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                stall = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            else
                stall = draw_wait();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
        end
    end

    // Walks through the error cases and the arithmetic corners, starting
    // from an empty stack. Operands of non-push tokens are random, to show
    // that they are ignored. The closing equals leaves the stack empty.
    task automatic test_directed_cases();
        pace = PACE_NONE;
        send_token(OP_EQ, $urandom());          // equals with nothing on the stack
        send_token(OP_ADD, $urandom());         // operator on an empty stack
        send_token(OP_PUSH, INT_MAX);
        send_token(OP_SUB, $urandom());         // operator with a single entry
        send_token(OP_PUSH, 32'sd1);
        send_token(OP_ADD, $urandom());         // wraps round to the most negative value
        send_token(OP_PUSH, -32'sd1);
        send_token(OP_DIV, $urandom());         // most negative over minus one wraps
        send_token(OP_PUSH, -32'sd1);
        send_token(OP_MOD, $urandom());         // and its remainder is zero
        send_token(OP_PUSH, 32'sd0);
        send_token(OP_DIV, $urandom());         // divide by zero
        send_token(OP_MOD, $urandom());         // modulus by zero
        send_token(OP_SPARE, INT_MIN);          // spare code is ignored
        send_token(OP_SUB, $urandom());
        send_token(OP_PUSH, -32'sd7);
        send_token(OP_PUSH, 32'sd2);
        send_token(OP_DIV, $urandom());         // truncates toward zero: -3
        send_token(OP_PUSH, 32'sd2);
        send_token(OP_MOD, $urandom());         // remainder keeps the dividend's sign
        send_token(OP_PUSH, 32'sd65536);
        send_token(OP_PUSH, 32'sd65537);
        send_token(OP_MUL, $urandom());         // product wraps at 32 bits
        send_token(OP_MUL, $urandom());
        send_token(OP_SUB, $urandom());
        send_token(OP_EQ, $urandom());
    endtask

    // Pushes past the stack depth after asking the result side to hold off, so that
    // the block fills its output register and stops taking tokens.
    task automatic test_full_stack_under_stall();
        pace = PACE_NONE;
        hold_request = 1'b1;
        repeat (STACK_ENTRIES + 2) send_token(OP_PUSH, draw_operand());
        send_token(OP_MUL, $urandom());
        send_token(OP_EQ, $urandom());
    endtask

    // Mostly well-formed expressions with random values and depths, each
    // closed by an equals. Now and then a short run of arbitrary tokens is
    // mixed in, spare code included. A high push bias drives the stack into
    // its full state, and a low one keeps it shallow. Pacing is redrawn for
    // every expression, so that some stretches run without any pauses.
    task automatic test_random_expressions(input int token_budget);
        int first;
        int push_bias;

        first = tokens_sent;
        while (tokens_sent - first < token_budget)
        begin
            pace = pace_t'($urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_token(3'($urandom_range(0, 7)), draw_operand());
            end
            else
            begin
                push_bias = $urandom_range(2, 8);
                repeat ($urandom_range(1, 30))
                begin
                    if (model_depth < 2 || $urandom_range(0, 9) < push_bias)
                        send_token(OP_PUSH, draw_operand());
                    else
                        send_token(3'($urandom_range(OP_ADD, OP_MOD)), draw_operand());
                end
                send_token(OP_EQ, draw_operand());
            end
        end
    endtask

    initial
    begin
        token_ch.valid   = 1'b0;
        token_ch.op      = OP_PUSH;
        token_ch.operand = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_full_stack_under_stall();
        test_random_expressions(RANDOM_TOKENS);
        token_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d tokens and checked %0d results, %0d of them completed expressions.",
                 tokens_sent, results_checked, finished_seen);
        $display("Error results: %0d underflow, %0d stack full, %0d divide by zero; %0d hold-off.",
                 status_seen[ST_UNDER], status_seen[ST_FULL], status_seen[ST_DIVZ], holds_done);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog. If it fires, a handshake has hung or results stopped coming.
    initial
    begin
        #(CLOCK_PERIOD * WATCHDOG_CYCLES);
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rpn_pkg.sv
design/rpn_token_if.sv
design/rpn_result_if.sv
design/rpn_alu.sv
design/rpn_integer_stack_evaluator_core.sv
test/rpn_integer_stack_evaluator_core_tb.sv
